// ===== src/rars_pkg.sv =====
// package for the rectangle add / rectangle sum fenwick block
// constants, types and small helpers; no dependencies
`default_nettype none
package rars_pkg;
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int RW = $clog2(MAX_ROWS + 2);
  localparam int CW = $clog2(MAX_COLS + 2);
  localparam int IW = (RW > CW) ? RW : CW;
  localparam int STRIDE = MAX_COLS + 1;
  localparam int DEPTH = (MAX_ROWS + 1) * (MAX_COLS + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int FW = 7;
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam logic [0:0] REG_ROWS = 1'b0;
  localparam logic [0:0] REG_COLS = 1'b1;

  typedef struct packed {
    logic [0:0] opcode;
    logic [FW-1:0] row_low;
    logic [FW-1:0] col_low;
    logic [FW-1:0] row_high;
    logic [FW-1:0] col_high;
    logic signed [31:0] delta;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] rect_sum;
  } out_item_t;

  typedef struct packed {
    logic [RW-1:0] nr;
    logic [CW-1:0] nc;
  } dims_t;

  typedef struct packed {
    logic          wr_en;
    logic [AW-1:0] addr;
    logic [63:0]   wd0;
    logic [63:0]   wd1;
    logic [63:0]   wd2;
    logic [63:0]   wd3;
  } mem_req_t;
endpackage
`default_nettype wire

// ===== src/rars_if.sv =====
// valid/ready channel carrying one payload type
// depends on rars_pkg for payload types
`default_nettype none
interface rars_in_if import rars_pkg::*; ();
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rars_out_if import rars_pkg::*; ();
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/rect_add_rect_sum_2d_fenwick.sv =====
// top level of the rectangle add / rectangle sum block
// depends on rars_pkg, rars_if, rars_cfg, rars_seq, rars_store
//
// channel   dir  payload
// in_ch     in   opcode, row_low, col_low, row_high, col_high, delta
// out_ch    out  rect_sum (queries only)
// apb       in   rows_in_use @0x0, cols_in_use @0x4
//
// one item at a time; each tree entry visited passes through address,
// ram read, modify/write and index step, and each corner adds steps
// for its weights.
// after reset a clearing pass writes zero to all 4225 entries before the first item.
// a query result holds in the output until taken; no new item meanwhile.
`default_nettype none
module rect_add_rect_sum_2d_fenwick import rars_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  rars_in_if.sink          in_ch,
  rars_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  dims_t dims;
  mem_req_t req;
  logic [63:0] rd0, rd1, rd2, rd3;

  rars_cfg u_cfg (.clk(clk), .rst(rst), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready), .dims(dims));

  rars_seq u_seq (.clk(clk), .rst(rst), .dims(dims), .in_ch(in_ch),
    .out_ch(out_ch), .req(req), .rd0(rd0), .rd1(rd1), .rd2(rd2), .rd3(rd3));

  rars_store u_store (.clk(clk), .req(req), .rd0(rd0), .rd1(rd1),
    .rd2(rd2), .rd3(rd3));
endmodule
`default_nettype wire

// ===== src/rars_ram.sv =====
// generic single port ram with registered read
// no dependencies
`default_nettype none
module rars_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== src/rars_store.sv =====
// the four tree stores, one ram each, sharing one address
// depends on rars_pkg and rars_ram
`default_nettype none
module rars_store import rars_pkg::*; (
  input  wire logic     clk,
  input  wire mem_req_t req,
  output logic [63:0]   rd0,
  output logic [63:0]   rd1,
  output logic [63:0]   rd2,
  output logic [63:0]   rd3
);
  rars_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_plain (.clk(clk), .we(req.wr_en),
    .addr(req.addr), .wdata(req.wd0), .rdata(rd0));
  rars_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_roww (.clk(clk), .we(req.wr_en),
    .addr(req.addr), .wdata(req.wd1), .rdata(rd1));
  rars_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_colw (.clk(clk), .we(req.wr_en),
    .addr(req.addr), .wdata(req.wd2), .rdata(rd2));
  rars_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_both (.clk(clk), .we(req.wr_en),
    .addr(req.addr), .wdata(req.wd3), .rdata(rd3));
endmodule
`default_nettype wire

// ===== src/rars_cfg.sv =====
// apb register file for rows_in_use and cols_in_use
// depends on rars_pkg; gives clamped dimensions to the sequencer
`default_nettype none
module rars_cfg import rars_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output dims_t            dims
);
  logic [FW-1:0] rows_in_use;
  logic [FW-1:0] cols_in_use;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= FW'(64);
      cols_in_use <= FW'(64);
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (paddr[2:2])
        REG_ROWS: rows_in_use <= pwdata[FW-1:0];
        REG_COLS: cols_in_use <= pwdata[FW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (paddr[2:2])
        REG_ROWS: prdata = {{(32-FW){1'b0}}, rows_in_use};
        REG_COLS: prdata = {{(32-FW){1'b0}}, cols_in_use};
        default: prdata = '0;
      endcase
    end
  end

  // clamp to storage
  always_comb begin
    dims.nr = (32'(rows_in_use) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(rows_in_use);
    dims.nc = (32'(cols_in_use) > MAX_COLS) ? CW'(MAX_COLS) : CW'(cols_in_use);
  end
endmodule
`default_nettype wire

// ===== src/rars_seq.sv =====
// sequencer: walks fenwick indices for four corners, read-modify-write for adds
// depends on rars_pkg; drives rars_store
`default_nettype none
module rars_seq import rars_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire dims_t     dims,
  rars_in_if.sink        in_ch,
  rars_out_if.source     out_ch,
  output mem_req_t       req,
  input  wire logic [63:0] rd0,
  input  wire logic [63:0] rd1,
  input  wire logic [63:0] rd2,
  input  wire logic [63:0] rd3
);
  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_CORNER = 4'd2,
    S_READ = 4'd3, S_WAIT = 4'd4, S_MOD = 4'd5, S_STEP = 4'd6,
    S_W1 = 4'd7, S_W2 = 4'd8, S_W3 = 4'd9, S_NEXT = 4'd10, S_OUT = 4'd11,
    S_M1 = 4'd12, S_M2 = 4'd13;

  logic [3:0] state;
  logic [AW-1:0] clr_addr;
  in_item_t item;
  logic [1:0] k;              // corner number
  logic [IW:0] cr, cc;        // corner coordinates, wide enough for 65
  logic [IW:0] wi, wj;        // current walk indices
  logic [63:0] v0, v1, v2, v3; // per-tree add values
  logic [63:0] a0, a1, a2, a3; // query accumulators
  logic [63:0] t0, t1;
  logic signed [63:0] total;
  logic neg;                   // corner sign
  logic skip;
  logic [IW:0] xr, yc;
  logic [AW-1:0] addr;
  logic [63:0] dv;
  logic [IW:0] lsb_i, lsb_j;

  assign dv = 64'(item.delta);
  assign addr = AW'(32'(wi) * STRIDE + 32'(wj));
  assign lsb_i = wi & (~wi + 1'b1);
  assign lsb_j = wj & (~wj + 1'b1);

  // corner coordinates and sign for corner k
  logic [IW:0] lo_r, lo_c, hi_r, hi_c;
  always_comb begin
    if (item.opcode == OP_ADD) begin
      lo_r = (IW+1)'(item.row_low);
      lo_c = (IW+1)'(item.col_low);
      hi_r = (IW+1)'(item.row_high) + 1'b1;
      hi_c = (IW+1)'(item.col_high) + 1'b1;
    end else begin
      lo_r = (IW+1)'(item.row_low) - 1'b1;
      lo_c = (IW+1)'(item.col_low) - 1'b1;
      hi_r = (IW+1)'(item.row_high);
      hi_c = (IW+1)'(item.col_high);
    end
  end

  always_comb begin
    case (k)
      2'd0: begin cr = lo_r; cc = lo_c; end
      2'd1: begin cr = hi_r; cc = hi_c; end
      2'd2: begin cr = lo_r; cc = hi_c; end
      default: begin cr = hi_r; cc = lo_c; end
    endcase
    neg = k[1];
    xr = cr + 1'b1;
    yc = cc + 1'b1;
    // query lo index may be -1 (all ones in this width): that is zero or below
    if (item.opcode == OP_ADD)
      skip = cr == 0 || cc == 0 || cr > (IW+1)'(dims.nr) || cc > (IW+1)'(dims.nc);
    else
      skip = cr == 0 || cc == 0 || cr[IW] || cc[IW];
  end

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data.rect_sum = total;

  always_comb begin
    req.wr_en = 1'b0;
    req.addr = addr;
    req.wd0 = rd0 + v0;
    req.wd1 = rd1 + v1;
    req.wd2 = rd2 + v2;
    req.wd3 = rd3 + v3;
    if (state == S_CLEAR) begin
      req.wr_en = 1'b1;
      req.addr = clr_addr;
      req.wd0 = '0; req.wd1 = '0; req.wd2 = '0; req.wd3 = '0;
    end else if (state == S_MOD && item.opcode == OP_ADD) begin
      req.wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      k <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == DEPTH - 1) state <= S_IDLE;
        end
        S_IDLE: if (in_ch.valid) begin
          item <= in_ch.data;
          k <= '0;
          total <= '0;
          state <= S_CORNER;
        end
        S_CORNER: begin
          a0 <= '0; a1 <= '0; a2 <= '0; a3 <= '0;
          if (skip) state <= S_NEXT;
          else begin
            if (item.opcode == OP_ADD) begin
              wi <= cr; wj <= cc;
              v0 <= neg ? -dv : dv;
              state <= S_M1;
            end else begin
              wi <= (cr > (IW+1)'(dims.nr)) ? (IW+1)'(dims.nr) : cr;
              wj <= (cc > (IW+1)'(dims.nc)) ? (IW+1)'(dims.nc) : cc;
              state <= (dims.nr == 0 || dims.nc == 0) ? S_W1 : S_READ;
            end
          end
        end
        S_M1: begin
          v1 <= 64'(cr) * v0;
          v2 <= 64'(cc) * v0;
          state <= S_M2;
        end
        S_M2: begin
          v3 <= 64'(cc) * v1;
          state <= S_READ;
        end
        S_READ: state <= S_WAIT;
        S_WAIT: state <= S_MOD;
        S_MOD: begin
          if (item.opcode == OP_QUERY) begin
            a0 <= a0 + rd0; a1 <= a1 + rd1; a2 <= a2 + rd2; a3 <= a3 + rd3;
          end
          state <= S_STEP;
        end
        S_STEP: begin
          state <= S_READ;
          if (item.opcode == OP_ADD) begin
            if (wj + lsb_j <= (IW+1)'(dims.nc)) wj <= wj + lsb_j;
            else begin
              wj <= cc;
              if (wi + lsb_i <= (IW+1)'(dims.nr)) wi <= wi + lsb_i;
              else state <= S_NEXT;
            end
          end else begin
            if ((wj & (wj - 1'b1)) != 0) wj <= wj & (wj - 1'b1);
            else begin
              wj <= (cc > (IW+1)'(dims.nc)) ? (IW+1)'(dims.nc) : cc;
              if ((wi & (wi - 1'b1)) != 0) wi <= wi & (wi - 1'b1);
              else state <= S_W1;
            end
          end
        end
        // combine a*xr*yc + d - b*yc - c*xr over the stages S_W1, S_W2 and S_W3
        S_W1: begin
          t0 <= a0 * 64'(xr);
          t1 <= a2 * 64'(xr);
          state <= S_W2;
        end
        S_W2: begin
          t0 <= (t0 - a1) * 64'(yc);
          state <= S_W3;
        end
        S_W3: begin
          total <= neg ? total - (t0 + a3 - t1) : total + (t0 + a3 - t1);
          state <= S_NEXT;
        end
        S_NEXT: begin
          k <= k + 1'b1;
          if (k == 2'd3) state <= (item.opcode == OP_QUERY) ? S_OUT : S_IDLE;
          else state <= S_CORNER;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== tb/rars_checker.sv =====
`timescale 1ns / 1ps
// scoreboard for the rectangle add / rectangle sum block: mirrors the four
// fenwick trees, predicts query sums and compares them; depends on rars_pkg
`default_nettype none
module rars_checker import rars_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire in_item_t    in_data,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire out_item_t   out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [31:0] cfg_data,
  output int               fail_count,
  output int               pending_sums
);
  logic [63:0] t_plain [DEPTH];
  logic [63:0] t_row   [DEPTH];
  logic [63:0] t_col   [DEPTH];
  logic [63:0] t_both  [DEPTH];
  logic [6:0] rows_cfg, cols_cfg;
  logic [63:0] sum_queue [$];

  assign pending_sums = sum_queue.size();

  function automatic int unsigned eff_rows();
    return (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
  endfunction

  function automatic int unsigned eff_cols();
    return (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
  endfunction

  function automatic void place_corner(int unsigned r, int unsigned c, logic [63:0] v);
    int unsigned nr, nc, i, j;
    logic [63:0] rv, cv;
    nr = eff_rows();
    nc = eff_cols();
    if (r == 0 || c == 0 || r > nr || c > nc) return;
    rv = 64'(r) * v;
    cv = 64'(c) * v;
    for (i = r; i <= nr; i += i & (~i + 1))
      for (j = c; j <= nc; j += j & (~j + 1)) begin
        t_plain[i*STRIDE+j] += v;
        t_row[i*STRIDE+j]   += rv;
        t_col[i*STRIDE+j]   += cv;
        t_both[i*STRIDE+j]  += 64'(c) * rv;
      end
  endfunction

  function automatic logic [63:0] corner_prefix(int r, int c);
    int unsigned wr, wc, i, j;
    logic [63:0] a, b, cc, d, xr, yc;
    if (r <= 0 || c <= 0) return 64'd0;
    wr = (r > eff_rows()) ? eff_rows() : r;
    wc = (c > eff_cols()) ? eff_cols() : c;
    a = 0; b = 0; cc = 0; d = 0;
    for (i = wr; i != 0; i &= i - 1)
      for (j = wc; j != 0; j &= j - 1) begin
        a += t_plain[i*STRIDE+j];
        b += t_row[i*STRIDE+j];
        cc += t_col[i*STRIDE+j];
        d += t_both[i*STRIDE+j];
      end
    xr = 64'(r + 1);
    yc = 64'(c + 1);
    return a * xr * yc + d - b * yc - cc * xr;
  endfunction

  function automatic void apply_item(in_item_t it);
    logic [63:0] dv;
    int lr, lc, hr, hc;
    dv = 64'(signed'(it.delta));
    if (it.opcode == OP_ADD) begin
      place_corner(it.row_low, it.col_low, dv);
      place_corner(it.row_high + 1, it.col_high + 1, dv);
      place_corner(it.row_low, it.col_high + 1, -dv);
      place_corner(it.row_high + 1, it.col_low, -dv);
    end else begin
      lr = int'(it.row_low) - 1;
      lc = int'(it.col_low) - 1;
      hr = it.row_high;
      hc = it.col_high;
      sum_queue.push_back(corner_prefix(hr, hc) + corner_prefix(lr, lc)
                          - corner_prefix(hr, lc) - corner_prefix(lr, hc));
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) begin
        t_plain[k] = 0; t_row[k] = 0; t_col[k] = 0; t_both[k] = 0;
      end
      rows_cfg = 7'd64;
      cols_cfg = 7'd64;
      sum_queue.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr[2] == REG_COLS) cols_cfg = cfg_data[6:0];
        else rows_cfg = cfg_data[6:0];
      end
      if (in_valid && in_ready) apply_item(in_data);
      if (out_valid && out_ready) begin
        if (sum_queue.size() == 0) begin
          $error("rect_sum: unexpected item, actual %0h", out_data.rect_sum);
          fail_count++;
        end else begin
          if (out_data.rect_sum !== sum_queue[0]) begin
            $error("rect_sum: expected %0h actual %0h", sum_queue[0], out_data.rect_sum);
            fail_count++;
          end
          void'(sum_queue.pop_front());
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/rect_add_rect_sum_2d_fenwick_test.sv =====
`timescale 1ns / 1ps
// stimulus and verdict for the rectangle add / rectangle sum block
// depends on rars_pkg, rars_if, the block and rars_checker
`default_nettype none
module rect_add_rect_sum_2d_fenwick_test import rars_pkg::*;;
  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;
  int fail_count, pending_sums;
  bit calm = 0;

  rars_in_if in_ch ();
  rars_out_if out_ch ();

  rect_add_rect_sum_2d_fenwick dut (
    .clk, .rst, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  rars_checker chk (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_we(psel && penable && pwrite && pready), .cfg_addr(paddr), .cfg_data(pwdata),
    .fail_count, .pending_sums
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver stalls at random except in the calm stretch
  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= 15);
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [6:0] val);
    @(negedge clk);
    psel <= 1; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= 32'(val);
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_item(logic op, logic [6:0] r1, logic [6:0] c1,
                           logic [6:0] r2, logic [6:0] c2, logic [31:0] dv);
    in_item_t it;
    it.opcode = op; it.row_low = r1; it.col_low = c1;
    it.row_high = r2; it.col_high = c2; it.delta = dv;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 15) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid <= 0;
  endtask

  // quiesce before a register write; adds leave no result so pad with the item time
  task automatic drain();
    while (pending_sums != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
  endtask

  function automatic logic [6:0] pick(int hi);
    int v;
    v = $urandom_range(99);
    if (v < 5) return 7'($urandom_range(127));
    if (v < 8) return 7'd0;
    return 7'($urandom_range(hi, 1));
  endfunction

  task automatic random_phase(int n, int hi);
    for (int k = 0; k < n; k++)
      send_item(logic'($urandom_range(1)), pick(hi), pick(hi), pick(hi), pick(hi), $urandom);
  endtask

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    repeat (10) @(posedge clk);
    rst <= 0;
    // full grid extremes
    send_item(OP_ADD, 1, 1, 64, 64, 32'h7fff_ffff);
    send_item(OP_QUERY, 1, 1, 64, 64, 0);
    send_item(OP_ADD, 64, 64, 64, 64, 32'h8000_0000);
    send_item(OP_QUERY, 64, 64, 64, 64, 32'hffff_ffff);
    send_item(OP_ADD, 10, 20, 5, 3, 32'd77);          // reversed rectangle
    send_item(OP_QUERY, 30, 30, 2, 2, 0);
    send_item(OP_ADD, 0, 0, 127, 127, 32'hffff_ffff); // zero low, far high
    send_item(OP_QUERY, 0, 0, 127, 127, 0);
    send_item(OP_QUERY, 1, 1, 100, 100, 0);
    send_item(OP_ADD, 127, 127, 127, 127, 32'd5);
    send_item(OP_QUERY, 127, 1, 127, 1, 32'hffff_ffff);
    send_item(OP_QUERY, 33, 17, 48, 63, 0);
    drain();
    write_reg(REG_ROWS, 7'd1);
    write_reg(REG_COLS, 7'd1);
    send_item(OP_ADD, 1, 1, 1, 1, 32'd9);
    send_item(OP_QUERY, 1, 1, 2, 2, 0);
    send_item(OP_QUERY, 1, 1, 64, 64, 0);
    random_phase(40, 4);
    drain();
    write_reg(REG_ROWS, 7'd0);
    write_reg(REG_COLS, 7'd127);
    send_item(OP_ADD, 1, 1, 5, 5, 32'd3);
    send_item(OP_QUERY, 1, 1, 5, 5, 0);
    random_phase(20, 64);
    drain();
    write_reg(REG_ROWS, 7'd100);
    write_reg(REG_COLS, 7'd0);
    random_phase(20, 64);
    drain();
    write_reg(REG_ROWS, 7'd13);
    write_reg(REG_COLS, 7'd9);
    random_phase(120, 16);
    calm = 1;
    random_phase(80, 16);
    calm = 0;
    drain();
    write_reg(REG_ROWS, 7'd64);
    write_reg(REG_COLS, 7'd64);
    random_phase(250, 64);
    while (pending_sums != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
